[rtl/core/bkt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Booking table package
// Shared types, command and result codes for the sorted booking table.
// ----------------------------------------------------------------------------
package bkt_pkg;

    localparam int BKT_CAPACITY = 16;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    typedef enum logic [2:0] {
        KIND_INSERTED = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_DELETED  = 3'd2,
        KIND_ABSENT   = 3'd3,
        KIND_MATCH    = 3'd4,
        KIND_NONE     = 3'd5
    } kind_t;

    typedef struct packed {
        logic [15:0] pet_id;
        logic [10:0] slot_time;
        logic [2:0]  specialty;
    } entry_t;

    typedef struct packed {
        kind_t      kind;
        entry_t     entry;
        logic [4:0] removed;
        logic       last;
    } res_t;

endpackage

[rtl/core/sorted_booking_table.sv]
`timescale 1ns / 1ps
// An insert answers after shifting up the entries with a larger pet id; a delete
// or the last query result after reading the whole table; an empty table or a
// full-table insert answers without a table walk; an output stall adds to each.
// Throughput: one transaction at a time, set by the single table read port, one
// entry per cycle, a query walk pausing while a match waits on a stalled output.
// Reset: entry count cleared, table contents left unchanged, output empty.
// ----------------------------------------------------------------------------
// Sorted booking table
// Bookings kept sorted by pet id with insert, delete-all and query-by-time.
// ----------------------------------------------------------------------------
module sorted_booking_table #(
    parameter int CAPACITY = bkt_pkg::BKT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_pet_id,
    input  logic [10:0] s_slot_time,
    input  logic [2:0]  s_specialty,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_match_id,
    output logic [10:0] m_match_time,
    output logic [2:0]  m_match_specialty,
    output logic [4:0]  m_removed_count,
    output logic        m_last
);
    import bkt_pkg::*;

    res_t res_data;
    res_t res_reg;
    logic res_push;
    logic out_free;
    logic m_valid_reg;

    assign out_free = !m_valid_reg || m_ready;

    bkt_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_pet_id    (s_pet_id),
        .s_slot_time (s_slot_time),
        .s_specialty (s_specialty),
        .out_free    (out_free),
        .res_push    (res_push),
        .res_data    (res_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) begin
            res_reg <= res_data;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kind            = res_reg.kind;
    assign m_match_id        = res_reg.entry.pet_id;
    assign m_match_time      = res_reg.entry.slot_time;
    assign m_match_specialty = res_reg.entry.specialty;
    assign m_removed_count   = res_reg.removed;
    assign m_last            = res_reg.last;

endmodule

[rtl/core/bkt_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Booking table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bkt_mem #(
    parameter int DEPTH = bkt_pkg::BKT_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic           aclk,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  bkt_pkg::entry_t wr_data,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output bkt_pkg::entry_t rd_data
);
    import bkt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/bkt_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Booking table sequencer
// Walks the table one entry per cycle for insert shift, delete compaction
// and query scan; a query pauses while a match waits on a stalled output.
// ----------------------------------------------------------------------------
module bkt_seq #(
    parameter int CAPACITY = bkt_pkg::BKT_CAPACITY
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_command,
    input  logic [15:0]      s_pet_id,
    input  logic [10:0]      s_slot_time,
    input  logic [2:0]       s_specialty,
    input  logic             out_free,
    output logic             res_push,
    output bkt_pkg::res_t    res_data
);
    import bkt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_INS  = 5'b00010,
        ST_DEL  = 5'b00100,
        ST_QRY  = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t       state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] wr_idx_reg, wr_idx_next;
    logic          pend_reg, pend_next;
    logic          held_vld_reg, held_vld_next;
    entry_t        key_reg, key_next;
    entry_t        held_reg, held_next;
    kind_t         kind_reg, kind_next;
    logic [4:0]    removed_reg, removed_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata, mem_rdata;
    entry_t        in_entry;
    logic          keep, hit, stall;
    logic [CW-1:0] w_new, diff;

    assign in_entry = '{pet_id: s_pet_id, slot_time: s_slot_time, specialty: s_specialty};
    assign s_ready  = (state_reg == ST_IDLE);
    assign keep     = (mem_rdata.pet_id != key_reg.pet_id);
    assign hit      = pend_reg && (mem_rdata.slot_time == key_reg.slot_time);
    assign stall    = hit && held_vld_reg && !out_free;
    assign w_new    = wr_idx_reg + {{(CW-1){1'b0}}, keep};
    assign diff     = count_reg - w_new;

    bkt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        pend_next     = pend_reg;
        held_vld_next = held_vld_reg;
        key_next      = key_reg;
        held_next     = held_reg;
        kind_next     = kind_reg;
        removed_next  = removed_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = key_reg;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        res_push      = 1'b0;
        res_data.kind    = kind_reg;
        res_data.entry   = held_reg;
        res_data.removed = '0;
        res_data.last    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next     = in_entry;
                    removed_next = '0;
                    unique case (s_command)
                        CMD_INSERT: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                kind_next  = KIND_FULL;
                                state_next = ST_RESP;
                            end else if (count_reg == '0) begin
                                mem_we     = 1'b1;
                                mem_wdata  = in_entry;
                                count_next = count_reg + CW'(1);
                                kind_next  = KIND_INSERTED;
                                state_next = ST_RESP;
                            end else begin
                                pos_next   = count_reg;
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(count_reg - CW'(1));
                                pend_next  = 1'b1;
                                state_next = ST_INS;
                            end
                        end
                        CMD_DELETE: begin
                            if (count_reg == '0) begin
                                kind_next  = KIND_ABSENT;
                                state_next = ST_RESP;
                            end else begin
                                mem_re      = 1'b1;
                                rd_idx_next = CW'(1);
                                wr_idx_next = '0;
                                pend_next   = 1'b1;
                                state_next  = ST_DEL;
                            end
                        end
                        CMD_QUERY: begin
                            if (count_reg == '0) begin
                                kind_next  = KIND_NONE;
                                state_next = ST_RESP;
                            end else begin
                                mem_re        = 1'b1;
                                rd_idx_next   = CW'(1);
                                pend_next     = 1'b1;
                                held_vld_next = 1'b0;
                                state_next    = ST_QRY;
                            end
                        end
                        CMD_NOP: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INS: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(pos_reg);
                if (pend_reg && (mem_rdata.pet_id > key_reg.pet_id)) begin
                    mem_wdata = mem_rdata;
                    pos_next  = pos_reg - CW'(1);
                    if (pos_reg > CW'(1)) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(pos_reg - CW'(2));
                        pend_next = 1'b1;
                    end else begin
                        pend_next = 1'b0;
                    end
                end else begin
                    mem_wdata  = key_reg;
                    count_next = count_reg + CW'(1);
                    kind_next  = KIND_INSERTED;
                    pend_next  = 1'b0;
                    state_next = ST_RESP;
                end
            end
            ST_DEL: begin
                if (keep) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(wr_idx_reg);
                    mem_wdata = mem_rdata;
                end
                wr_idx_next = w_new;
                if (rd_idx_reg < count_reg) begin
                    mem_re      = 1'b1;
                    mem_raddr   = AW'(rd_idx_reg);
                    rd_idx_next = rd_idx_reg + CW'(1);
                end else begin
                    removed_next = 5'(diff);
                    kind_next    = (diff != '0) ? KIND_DELETED : KIND_ABSENT;
                    count_next   = w_new;
                    pend_next    = 1'b0;
                    state_next   = ST_RESP;
                end
            end
            ST_QRY: begin
                if (!stall) begin
                    if (hit) begin
                        res_push      = held_vld_reg;
                        res_data.kind = KIND_MATCH;
                        held_next     = mem_rdata;
                        held_vld_next = 1'b1;
                    end
                    if (rd_idx_reg < count_reg) begin
                        mem_re      = 1'b1;
                        mem_raddr   = AW'(rd_idx_reg);
                        rd_idx_next = rd_idx_reg + CW'(1);
                    end else begin
                        pend_next  = 1'b0;
                        kind_next  = (hit || held_vld_reg) ? KIND_MATCH : KIND_NONE;
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    res_push         = 1'b1;
                    res_data.kind    = kind_reg;
                    res_data.entry   = (kind_reg == KIND_MATCH) ? held_reg : '0;
                    res_data.removed = removed_reg;
                    res_data.last    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            held_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            held_vld_reg <= held_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        rd_idx_reg  <= rd_idx_next;
        wr_idx_reg  <= wr_idx_next;
        key_reg     <= key_next;
        held_reg    <= held_next;
        kind_reg    <= kind_next;
        removed_reg <= removed_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> out_free)
        else $error("result pushed into a full output register");

    a_del_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEL) |-> (pend_reg && (wr_idx_reg < rd_idx_reg)))
        else $error("delete write index passed read index");

    a_ins_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS) |-> (pos_reg <= count_reg && count_reg < CW'(CAPACITY)))
        else $error("insert position out of range");

    a_qry_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QRY && stall) |=> $stable(held_reg))
        else $error("held match changed during output stall");

endmodule
